### hdl/eat_pkg.sv
// Package for the expiring address table: request and result item types,
// status and command codes, default sizes. No dependencies.
package eat_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam logic [31:0] HOLD_TIME_RESET = 32'd30000;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_DELETED = 2'd3
    } t_status;

    typedef struct packed {
        logic        command;
        logic [31:0] ip_address;
        logic [31:0] now;
    } t_eat_req;

    typedef struct packed {
        t_status     status;
        logic [5:0]  slot;
    } t_eat_rsp;

endpackage

### hdl/expiring_address_table.sv
// Expiring address table: top level with the entry memory and scan sequencer.
// Depends on eat_pkg.
//
// Each request walks the table in index order through one synchronous memory
// (one read and one write port, registered read data). A scan issues one
// read per entry and evaluates each entry as its read data returns; then
// an added entry is written and the result loaded once the output register
// is free, and the sequencer returns to idle. An add that hits a live match
// stops early. Expired entries met on an add, and matching entries on a
// delete, are invalidated in place as the scan passes. After reset a
// clearing pass marks every entry invalid; no item is accepted meanwhile,
// but hold_time writes are taken at any time. The result is held in an output
// register, so the next item is accepted while a result still waits.
module expiring_address_table #(
    parameter int ENTRIES = eat_pkg::ENTRIES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  eat_pkg::t_eat_req i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output eat_pkg::t_eat_rsp o_out_item,
    input  logic              i_cfg_wr_en,
    input  logic [31:0]       i_cfg_wr_data
);
    import eat_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] expiry;
    } t_entry;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state          r_state;
    t_eat_req        r_req;
    logic [31:0]     r_hold;
    logic [AW-1:0]   r_clr_idx;
    logic [AW-1:0]   r_issue_idx;
    logic            r_issue_on;
    logic [AW-1:0]   r_ev_idx;
    logic            r_ev_vld;
    logic            r_have_free;
    logic [AW-1:0]   r_free_idx;
    logic            r_present;
    logic            r_out_valid;
    t_eat_rsp        r_out_item;

    t_entry          r_mem [ENTRIES];
    t_entry          r_rd_data;

    logic            in_accept;
    logic            out_free;
    logic            ev_live;
    logic            ev_expired;
    logic            ev_match;
    logic            ev_is_add;
    logic            ev_take_free;
    logic            ev_hit;
    logic            ev_stop;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;
    t_eat_rsp        n_out_item;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // evaluation of the entry whose read data arrived this cycle
    assign ev_is_add    = (r_req.command == CMD_ADD);
    assign ev_live      = r_rd_data.valid;
    assign ev_expired   = ev_live && (r_req.now > r_rd_data.expiry);
    assign ev_match     = ev_live && (r_rd_data.address == r_req.ip_address);
    assign ev_take_free = r_ev_vld && ev_is_add && !r_have_free && (!ev_live || ev_expired);
    assign ev_hit       = r_ev_vld && ev_is_add && !ev_expired && ev_match;
    assign ev_stop      = r_ev_vld && (ev_hit || (r_ev_idx == LAST));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ev_idx;
        wr_data = r_rd_data;
        wr_data.valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
                wr_data = '0;
            end
            S_SCAN: begin
                // invalidate in place: expired on add, any match on delete
                wr_en = r_ev_vld && (ev_is_add ? ev_expired : ev_match);
            end
            S_DONE: begin
                wr_en   = out_free && ev_is_add && !r_present && r_have_free;
                wr_addr = r_free_idx;
                wr_data.valid   = 1'b1;
                wr_data.address = r_req.ip_address;
                wr_data.expiry  = r_req.now + r_hold;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_item.slot = '0;
        if (!ev_is_add) begin
            n_out_item.status = ST_DELETED;
        end else if (r_present) begin
            n_out_item.status = ST_PRESENT;
        end else if (r_have_free) begin
            n_out_item.status = ST_ADDED;
            n_out_item.slot   = 6'(r_free_idx);
        end else begin
            n_out_item.status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_issue_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_hold      <= HOLD_TIME_RESET;
            r_clr_idx   <= '0;
            r_issue_idx <= '0;
            r_issue_on  <= 1'b0;
            r_ev_idx    <= '0;
            r_ev_vld    <= 1'b0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_hold <= i_cfg_wr_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_item  <= n_out_item;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_req       <= i_in_item;
                        r_issue_idx <= '0;
                        r_issue_on  <= 1'b1;
                        r_ev_vld    <= 1'b0;
                        r_have_free <= 1'b0;
                        r_present   <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (ev_take_free) begin
                        r_have_free <= 1'b1;
                        r_free_idx  <= r_ev_idx;
                    end
                    if (ev_hit) begin
                        r_present <= 1'b1;
                    end
                    if (ev_stop) begin
                        r_issue_on <= 1'b0;
                        r_ev_vld   <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        r_ev_vld <= r_issue_on;
                        r_ev_idx <= r_issue_idx;
                        if (r_issue_on) begin
                            r_issue_idx <= r_issue_idx + 1'b1;
                            r_issue_on  <= (r_issue_idx != LAST);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // the in-place write of one entry never collides with the next read
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && wr_en && r_issue_on) |-> (wr_addr != r_issue_idx))
        else $error("scan write hits the entry being read");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_SCAN && !r_ev_vld))
        else $error("accepted item did not start a fresh scan");

    a_ev_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> !r_ev_vld)
        else $error("entry evaluated outside a scan");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not loaded at end of scan");
`endif

endmodule
